@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the frame table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SFRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SFRT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sfrt_pkg.sv @@
// Package with the types and constants of the shared frame reference-count table.
`default_nettype none

package sfrt_pkg;

  localparam int SEQ_W  = 32;
  localparam int REF_W  = 4;
  localparam int STAT_W = 3;

  localparam logic [REF_W-1:0] REF_MAX = 4'd15;
  localparam logic [REF_W-1:0] REF_ONE = 4'd1;

  localparam logic [STAT_W-1:0] STAT_SHARED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_HELD     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOFRAME  = 3'd5;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    logic is_put;
    logic hit;
    logic empty_found;
  } scan_ctl_t;

  typedef struct packed {
    logic wr;
    logic occ;
  } slot_wr_t;

endpackage

`default_nettype wire

@@ rtl/sfrt_cell.sv @@
// One table slot: holds the slot state and forwards the search packet to the next slot.
`default_nettype none

module sfrt_cell import sfrt_pkg::*; #(
  parameter int MODULES = 8,
  parameter int BUF_W   = 3,
  parameter int SLOT_W  = 4,
  parameter int IDX     = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  scan_ctl_t              ctl_i,
  input  wire  [MODULES-1:0]     mask_i,
  input  wire  [BUF_W-1:0]       pbuf_i,
  input  wire  [SLOT_W-1:0]      hit_slot_i,
  input  wire  [BUF_W-1:0]       hit_buf_i,
  input  wire  [MODULES-1:0]     hit_cons_i,
  input  wire  [REF_W-1:0]       hit_refs_i,
  input  wire  [SLOT_W-1:0]      empty_slot_i,
  output scan_ctl_t              ctl_o,
  output logic [MODULES-1:0]     mask_o,
  output logic [BUF_W-1:0]       pbuf_o,
  output logic [SLOT_W-1:0]      hit_slot_o,
  output logic [BUF_W-1:0]       hit_buf_o,
  output logic [MODULES-1:0]     hit_cons_o,
  output logic [REF_W-1:0]       hit_refs_o,
  output logic [SLOT_W-1:0]      empty_slot_o,
  input  slot_wr_t               wr_i,
  input  wire  [SLOT_W-1:0]      wr_slot_i,
  input  wire  [BUF_W-1:0]       wr_buf_i,
  input  wire  [MODULES-1:0]     wr_cons_i,
  input  wire  [REF_W-1:0]       wr_refs_i
);

  logic               occ_r;
  logic [BUF_W-1:0]   buf_r;
  logic [MODULES-1:0] cons_r;
  logic [REF_W-1:0]   refs_r;

  scan_ctl_t          ctl_r, ctl_nxt;
  logic [MODULES-1:0] mask_r;
  logic [BUF_W-1:0]   pbuf_r;
  logic [SLOT_W-1:0]  hit_slot_r, hit_slot_nxt;
  logic [BUF_W-1:0]   hit_buf_r, hit_buf_nxt;
  logic [MODULES-1:0] hit_cons_r, hit_cons_nxt;
  logic [REF_W-1:0]   hit_refs_r, hit_refs_nxt;
  logic [SLOT_W-1:0]  empty_slot_r, empty_slot_nxt;

  logic match;
  logic take;

  always_comb begin
    match = ctl_i.is_put ? (occ_r && (buf_r == pbuf_i))
                         : (occ_r && ((cons_r & mask_i) == '0));
    take  = ctl_i.valid && !ctl_i.hit && match;

    ctl_nxt        = ctl_i;
    hit_slot_nxt   = hit_slot_i;
    hit_buf_nxt    = hit_buf_i;
    hit_cons_nxt   = hit_cons_i;
    hit_refs_nxt   = hit_refs_i;
    empty_slot_nxt = empty_slot_i;
    if (take) begin
      ctl_nxt.hit  = 1'b1;
      hit_slot_nxt = SLOT_W'(IDX);
      hit_buf_nxt  = buf_r;
      hit_cons_nxt = cons_r;
      hit_refs_nxt = refs_r;
    end
    if (ctl_i.valid && !ctl_i.empty_found && !occ_r) begin
      ctl_nxt.empty_found = 1'b1;
      empty_slot_nxt      = SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r       <= mask_i;
    pbuf_r       <= pbuf_i;
    hit_slot_r   <= hit_slot_nxt;
    hit_buf_r    <= hit_buf_nxt;
    hit_cons_r   <= hit_cons_nxt;
    hit_refs_r   <= hit_refs_nxt;
    empty_slot_r <= empty_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      buf_r  <= '0;
      cons_r <= '0;
      refs_r <= '0;
    end else if (wr_i.wr && (wr_slot_i == SLOT_W'(IDX))) begin
      occ_r  <= wr_i.occ;
      buf_r  <= wr_buf_i;
      cons_r <= wr_cons_i;
      refs_r <= wr_refs_i;
    end
  end

  assign ctl_o        = ctl_r;
  assign mask_o       = mask_r;
  assign pbuf_o       = pbuf_r;
  assign hit_slot_o   = hit_slot_r;
  assign hit_buf_o    = hit_buf_r;
  assign hit_cons_o   = hit_cons_r;
  assign hit_refs_o   = hit_refs_r;
  assign empty_slot_o = empty_slot_r;

endmodule

`default_nettype wire

@@ rtl/shared_frame_refcount_table.sv @@
// Top level of the shared frame reference-count table.
// Each request runs a search packet through a row of SLOTS slot cells, one cell per clock, starting
// at the accepting edge. The end of the row is then captured in a register while the sequence
// memory is read, and after that the result is registered and the chosen slot updated, as soon as
// no earlier result is still waiting to be taken.
// One request is handled at a time; the next is accepted in the cycle after the result has been
// registered, even if that result has not yet been taken, and a result that is still waiting
// holds the following one back. Every request produces exactly one result transaction.
`default_nettype none

module shared_frame_refcount_table import sfrt_pkg::*; #(
  parameter int MODULES = 8,
  parameter int SLOTS   = 9,
  parameter int BUFFERS = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_req_type,
  input  wire  [MODULES-1:0]           in_module_mask,
  input  wire  [$clog2(BUFFERS)-1:0]   in_put_buffer,
  input  wire                          in_capture_ready,
  input  wire  [$clog2(BUFFERS)-1:0]   in_capture_buffer,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [STAT_W-1:0]            out_status,
  output logic [$clog2(BUFFERS)-1:0]   out_buffer_index,
  output logic [SEQ_W-1:0]             out_frame_seq,
  output logic                         out_requeue,
  output logic                         out_consume_capture,
  output logic [$clog2(SLOTS)-1:0]     out_slot_used,
  output logic [REF_W-1:0]             out_ref_count
);

  localparam int BUF_W  = $clog2(BUFFERS);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [BUF_W:0] BUF_LIMIT = (BUF_W+1)'(BUFFERS);

  state_t state_r, state_nxt;

  scan_ctl_t          ctl_w        [SLOTS+1];
  logic [MODULES-1:0] mask_w       [SLOTS+1];
  logic [BUF_W-1:0]   pbuf_w       [SLOTS+1];
  logic [SLOT_W-1:0]  hit_slot_w   [SLOTS+1];
  logic [BUF_W-1:0]   hit_buf_w    [SLOTS+1];
  logic [MODULES-1:0] hit_cons_w   [SLOTS+1];
  logic [REF_W-1:0]   hit_refs_w   [SLOTS+1];
  logic [SLOT_W-1:0]  empty_slot_w [SLOTS+1];

  logic               accept;
  logic               tail_valid;
  logic               done_fire;

  logic               req_cap_ready_r;
  logic [BUF_W-1:0]   req_cap_r;
  logic [MODULES-1:0] req_mask_r;
  logic [BUF_W-1:0]   req_pbuf_r;

  scan_ctl_t          tail_ctl_r;
  logic [SLOT_W-1:0]  tail_slot_r;
  logic [BUF_W-1:0]   tail_buf_r;
  logic [MODULES-1:0] tail_cons_r;
  logic [REF_W-1:0]   tail_refs_r;
  logic [SLOT_W-1:0]  tail_empty_r;

  logic [SEQ_W-1:0]   seq_mem [BUFFERS];
  logic [SEQ_W-1:0]   rd_seq_r;
  logic [SEQ_W-1:0]   next_seq_r;

  logic               cap_ok;
  logic [REF_W-1:0]   refs_inc;
  logic [REF_W-1:0]   refs_dec;

  logic [STAT_W-1:0]  res_status;
  logic [BUF_W-1:0]   res_buf;
  logic [SEQ_W-1:0]   res_seq;
  logic               res_requeue;
  logic               res_consume;
  logic [SLOT_W-1:0]  res_slot;
  logic [REF_W-1:0]   res_refs;
  logic               new_frame;

  slot_wr_t           wr;
  logic [SLOT_W-1:0]  wr_slot;
  logic [BUF_W-1:0]   wr_buf;
  logic [MODULES-1:0] wr_cons;
  logic [REF_W-1:0]   wr_refs;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [BUF_W-1:0]   out_buffer_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic               out_requeue_r;
  logic               out_consume_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [REF_W-1:0]   out_refs_r;

  assign accept     = in_valid && in_ready;
  assign tail_valid = ctl_w[SLOTS].valid;
  assign done_fire  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign ctl_w[0].valid       = accept;
  assign ctl_w[0].is_put      = in_req_type;
  assign ctl_w[0].hit         = 1'b0;
  assign ctl_w[0].empty_found = 1'b0;
  assign mask_w[0]            = in_module_mask;
  assign pbuf_w[0]            = in_put_buffer;
  assign hit_slot_w[0]        = '0;
  assign hit_buf_w[0]         = '0;
  assign hit_cons_w[0]        = '0;
  assign hit_refs_w[0]        = '0;
  assign empty_slot_w[0]      = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sfrt_cell #(
      .MODULES (MODULES),
      .BUF_W   (BUF_W),
      .SLOT_W  (SLOT_W),
      .IDX     (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl_w[g]),
      .mask_i       (mask_w[g]),
      .pbuf_i       (pbuf_w[g]),
      .hit_slot_i   (hit_slot_w[g]),
      .hit_buf_i    (hit_buf_w[g]),
      .hit_cons_i   (hit_cons_w[g]),
      .hit_refs_i   (hit_refs_w[g]),
      .empty_slot_i (empty_slot_w[g]),
      .ctl_o        (ctl_w[g+1]),
      .mask_o       (mask_w[g+1]),
      .pbuf_o       (pbuf_w[g+1]),
      .hit_slot_o   (hit_slot_w[g+1]),
      .hit_buf_o    (hit_buf_w[g+1]),
      .hit_cons_o   (hit_cons_w[g+1]),
      .hit_refs_o   (hit_refs_w[g+1]),
      .empty_slot_o (empty_slot_w[g+1]),
      .wr_i         (wr),
      .wr_slot_i    (wr_slot),
      .wr_buf_i     (wr_buf),
      .wr_cons_i    (wr_cons),
      .wr_refs_i    (wr_refs)
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cap_ready_r <= in_capture_ready;
      req_cap_r       <= in_capture_buffer;
      req_mask_r      <= in_module_mask;
      req_pbuf_r      <= in_put_buffer;
    end
    if ((state_r == ST_SCAN) && tail_valid) begin
      tail_ctl_r   <= ctl_w[SLOTS];
      tail_slot_r  <= hit_slot_w[SLOTS];
      tail_buf_r   <= hit_buf_w[SLOTS];
      tail_cons_r  <= hit_cons_w[SLOTS];
      tail_refs_r  <= hit_refs_w[SLOTS];
      tail_empty_r <= empty_slot_w[SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire && new_frame) begin
      seq_mem[req_cap_r] <= next_seq_r;
    end
    if ((state_r == ST_SCAN) && tail_valid) begin
      rd_seq_r <= seq_mem[hit_buf_w[SLOTS]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r <= '0;
    end else if (done_fire && new_frame) begin
      next_seq_r <= next_seq_r + SEQ_W'(1);
    end
  end

  assign cap_ok   = req_cap_ready_r && ({1'b0, req_cap_r} < BUF_LIMIT);
  assign refs_inc = (tail_refs_r == REF_MAX) ? REF_MAX : (tail_refs_r + REF_ONE);
  assign refs_dec = tail_refs_r - REF_ONE;

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    res_status  = STAT_NOTFOUND;
    res_buf     = '0;
    res_seq     = '0;
    res_requeue = 1'b0;
    res_consume = 1'b0;
    res_slot    = '0;
    res_refs    = '0;
    new_frame   = 1'b0;
    wr          = '0;
    wr_slot     = tail_slot_r;
    wr_buf      = tail_buf_r;
    wr_cons     = tail_cons_r;
    wr_refs     = '0;
    priority if (tail_ctl_r.is_put) begin
      if (!tail_ctl_r.hit || ((tail_cons_r & req_mask_r) == '0) || (tail_refs_r == '0)) begin
        res_status = STAT_NOTFOUND;
      end else if (refs_dec != '0) begin
        res_status = STAT_HELD;
        res_buf    = req_pbuf_r;
        res_slot   = tail_slot_r;
        res_refs   = refs_dec;
        wr.wr      = 1'b1;
        wr.occ     = 1'b1;
        wr_refs    = refs_dec;
      end else begin
        res_status  = STAT_RELEASED;
        res_buf     = req_pbuf_r;
        res_requeue = 1'b1;
        res_slot    = tail_slot_r;
        wr.wr       = 1'b1;
        wr.occ      = 1'b0;
        wr_buf      = '0;
        wr_cons     = '0;
      end
    end else if (tail_ctl_r.hit) begin
      res_status = STAT_SHARED;
      res_buf    = tail_buf_r;
      res_seq    = rd_seq_r;
      res_slot   = tail_slot_r;
      res_refs   = refs_inc;
      wr.wr      = 1'b1;
      wr.occ     = 1'b1;
      wr_cons    = tail_cons_r | req_mask_r;
      wr_refs    = refs_inc;
    end else if (!tail_ctl_r.empty_found) begin
      res_status = STAT_FULL;
    end else if (!cap_ok) begin
      res_status = STAT_NOFRAME;
    end else begin
      res_status  = STAT_NEW;
      res_buf     = req_cap_r;
      res_seq     = next_seq_r;
      res_consume = 1'b1;
      res_slot    = tail_empty_r;
      res_refs    = REF_ONE;
      new_frame   = 1'b1;
      wr.wr       = 1'b1;
      wr.occ      = 1'b1;
      wr_slot     = tail_empty_r;
      wr_buf      = req_cap_r;
      wr_cons     = req_mask_r;
      wr_refs     = REF_ONE;
    end
    wr.wr = wr.wr && done_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_status_r  <= res_status;
      out_buffer_r  <= res_buf;
      out_seq_r     <= res_seq;
      out_requeue_r <= res_requeue;
      out_consume_r <= res_consume;
      out_slot_r    <= res_slot;
      out_refs_r    <= res_refs;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_buffer_index    = out_buffer_r;
  assign out_frame_seq       = out_seq_r;
  assign out_requeue         = out_requeue_r;
  assign out_consume_capture = out_consume_r;
  assign out_slot_used       = out_slot_r;
  assign out_ref_count       = out_refs_r;

endmodule

`default_nettype wire

@@ rtl/sfrt_checker.sv @@
// Port-level assertion checker for the shared frame reference-count table, with its bind.
`default_nettype none

`include "assert_macros.svh"

module sfrt_checker import sfrt_pkg::*; #(
  parameter int MODULES = 8,
  parameter int SLOTS   = 9,
  parameter int BUFFERS = 8
) (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_req_type,
  input wire [MODULES-1:0]          in_module_mask,
  input wire [$clog2(BUFFERS)-1:0]  in_put_buffer,
  input wire                        in_capture_ready,
  input wire [$clog2(BUFFERS)-1:0]  in_capture_buffer,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [STAT_W-1:0]           out_status,
  input wire [$clog2(BUFFERS)-1:0]  out_buffer_index,
  input wire [SEQ_W-1:0]            out_frame_seq,
  input wire                        out_requeue,
  input wire                        out_consume_capture,
  input wire [$clog2(SLOTS)-1:0]    out_slot_used,
  input wire [REF_W-1:0]            out_ref_count
);

  `SFRT_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `SFRT_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second request taken during a search")

  `SFRT_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(out_frame_seq) && $stable(out_status)), "stalled result changed")

  `SFRT_ASSERT(a_consume_is_new, (out_valid && out_consume_capture) |-> (out_status == STAT_NEW && out_ref_count == REF_ONE && !out_requeue), "capture taken without a new frame")

  `SFRT_ASSERT(a_requeue_released, (out_valid && out_requeue) |-> (out_status == STAT_RELEASED && out_ref_count == '0 && out_frame_seq == '0), "requeue without a release")

endmodule

bind shared_frame_refcount_table sfrt_checker #(
  .MODULES (MODULES),
  .SLOTS   (SLOTS),
  .BUFFERS (BUFFERS)
) u_sfrt_checker (.*);

`default_nettype wire

@@ test/shared_frame_refcount_table_tb.sv @@
// Self-checking testbench for the shared frame reference-count table.
module shared_frame_refcount_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrt_pkg::*;

  localparam int MODULES = 8;
  localparam int SLOTS = 9;
  localparam int BUFFERS = 8;
  localparam int BUF_W = $clog2(BUFFERS);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int RANDOM_REQUESTS = 1250;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [MODULES-1:0] module_mask;
    logic [BUF_W-1:0]   put_buffer;
    logic               capture_ready;
    logic [BUF_W-1:0]   capture_buffer;
  } frame_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BUF_W-1:0]  buffer_index;
    logic [SEQ_W-1:0]  frame_seq;
    logic              requeue;
    logic              consume_capture;
    logic [SLOT_W-1:0] slot_used;
    logic [REF_W-1:0]  ref_count;
  } frame_reply_t;

  class frame_share_tracker;
    bit                 occupied[SLOTS];
    logic [BUF_W-1:0]   slot_buf[SLOTS];
    logic [MODULES-1:0] consumers[SLOTS];
    logic [REF_W-1:0]   refs[SLOTS];
    logic [SEQ_W-1:0]   buf_seq[BUFFERS];
    logic [SEQ_W-1:0]   next_seq;
    frame_reply_t       awaited[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        slot_buf[i] = '0;
        consumers[i] = '0;
        refs[i] = '0;
      end
      for (int b = 0; b < BUFFERS; b++) begin
        buf_seq[b] = '0;
      end
      next_seq = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function frame_reply_t predict_reply(frame_req_t r);
      frame_reply_t rep;
      int spare;
      int hit;
      rep = '0;
      spare = -1;
      hit = -1;
      if (r.req_type == REQ_GET) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0) begin
            if (spare < 0 && !occupied[i]) begin
              spare = i;
            end
            if (occupied[i] && (consumers[i] & r.module_mask) == '0) begin
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          consumers[hit] = consumers[hit] | r.module_mask;
          if (refs[hit] < REF_MAX) begin
            refs[hit] = refs[hit] + 1'b1;
          end
          rep.status = STAT_SHARED;
          rep.buffer_index = slot_buf[hit];
          rep.frame_seq = buf_seq[slot_buf[hit]];
          rep.slot_used = hit[SLOT_W-1:0];
          rep.ref_count = refs[hit];
        end else if (spare < 0) begin
          rep.status = STAT_FULL;
        end else if (!r.capture_ready || int'(r.capture_buffer) >= BUFFERS) begin
          rep.status = STAT_NOFRAME;
        end else begin
          buf_seq[r.capture_buffer] = next_seq;
          next_seq = next_seq + 1'b1;
          occupied[spare] = 1'b1;
          slot_buf[spare] = r.capture_buffer;
          consumers[spare] = r.module_mask;
          refs[spare] = REF_ONE;
          rep.status = STAT_NEW;
          rep.buffer_index = r.capture_buffer;
          rep.frame_seq = buf_seq[r.capture_buffer];
          rep.consume_capture = 1'b1;
          rep.slot_used = spare[SLOT_W-1:0];
          rep.ref_count = REF_ONE;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && occupied[i] && slot_buf[i] == r.put_buffer) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          rep.status = STAT_NOTFOUND;
        end else if ((consumers[hit] & r.module_mask) == '0 || refs[hit] == '0) begin
          rep.status = STAT_NOTFOUND;
        end else begin
          refs[hit] = refs[hit] - 1'b1;
          rep.buffer_index = r.put_buffer;
          rep.slot_used = hit[SLOT_W-1:0];
          rep.ref_count = refs[hit];
          if (refs[hit] != '0) begin
            rep.status = STAT_HELD;
          end else begin
            occupied[hit] = 1'b0;
            slot_buf[hit] = '0;
            consumers[hit] = '0;
            rep.status = STAT_RELEASED;
            rep.requeue = 1'b1;
          end
        end
      end
      return rep;
    endfunction

    function void note_request(frame_req_t r);
      awaited.push_back(predict_reply(r));
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
    endtask

    task check_reply(frame_reply_t got);
      frame_reply_t want;
      if (awaited.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want = awaited.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("buffer_index", got.buffer_index, want.buffer_index);
        compare_field("frame_seq", got.frame_seq, want.frame_seq);
        compare_field("requeue", got.requeue, want.requeue);
        compare_field("consume_capture", got.consume_capture, want.consume_capture);
        compare_field("slot_used", got.slot_used, want.slot_used);
        compare_field("ref_count", got.ref_count, want.ref_count);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = 1'b0;
  logic [MODULES-1:0] in_module_mask = '0;
  logic [BUF_W-1:0]   in_put_buffer = '0;
  logic               in_capture_ready = 1'b0;
  logic [BUF_W-1:0]   in_capture_buffer = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [BUF_W-1:0]   out_buffer_index;
  logic [SEQ_W-1:0]   out_frame_seq;
  logic               out_requeue;
  logic               out_consume_capture;
  logic [SLOT_W-1:0]  out_slot_used;
  logic [REF_W-1:0]   out_ref_count;

  frame_share_tracker tracker = new();
  bit calm = 1'b0;
  int zero_mask_run = 0;

  shared_frame_refcount_table #(
    .MODULES(MODULES),
    .SLOTS  (SLOTS),
    .BUFFERS(BUFFERS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_module_mask     (in_module_mask),
    .in_put_buffer      (in_put_buffer),
    .in_capture_ready   (in_capture_ready),
    .in_capture_buffer  (in_capture_buffer),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_buffer_index   (out_buffer_index),
    .out_frame_seq      (out_frame_seq),
    .out_requeue        (out_requeue),
    .out_consume_capture(out_consume_capture),
    .out_slot_used      (out_slot_used),
    .out_ref_count      (out_ref_count)
  );

  always #1 clk = ~clk;

  function automatic frame_req_t compose_request(logic kind, logic [MODULES-1:0] mask,
                                                 logic [BUF_W-1:0] pbuf, logic rdy,
                                                 logic [BUF_W-1:0] cbuf);
    frame_req_t r;
    r.req_type = kind;
    r.module_mask = mask;
    r.put_buffer = pbuf;
    r.capture_ready = rdy;
    r.capture_buffer = cbuf;
    return r;
  endfunction

  function automatic frame_req_t draw_request();
    frame_req_t r;
    int busy;
    int roll;
    int k;
    int pick;
    int bit_no;
    r.req_type = REQ_GET;
    r.module_mask = MODULES'($urandom);
    r.put_buffer = BUF_W'($urandom);
    r.capture_ready = ($urandom_range(99) < 90);
    r.capture_buffer = BUF_W'($urandom);
    busy = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tracker.occupied[i]) begin
        busy++;
      end
    end
    roll = $urandom_range(99);
    if (zero_mask_run > 0) begin
      zero_mask_run--;
      r.module_mask = '0;
    end else if (roll < 8) begin
      r.req_type = logic'($urandom_range(1));
      r.capture_ready = logic'($urandom_range(1));
    end else if (roll == 8) begin
      zero_mask_run = 16;
      r.module_mask = '0;
    end else if (busy == 0 ||
                 $urandom_range(99) < (busy < 3 ? 75 : (busy > 7 ? 30 : 50))) begin
      roll = $urandom_range(19);
      if (roll < 12) begin
        r.module_mask = MODULES'(1) << $urandom_range(MODULES - 1);
      end else if (roll == 18) begin
        r.module_mask = '0;
      end else if (roll == 19) begin
        r.module_mask = '1;
      end
    end else begin
      r.req_type = REQ_PUT;
      k = $urandom_range(busy - 1);
      pick = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tracker.occupied[i]) begin
          if (k == 0) begin
            pick = i;
          end
          k--;
        end
      end
      r.put_buffer = tracker.slot_buf[pick];
      if (tracker.consumers[pick] != '0 && $urandom_range(99) < 85) begin
        bit_no = $urandom_range(MODULES - 1);
        while (!tracker.consumers[pick][bit_no]) begin
          bit_no = (bit_no + 1) % MODULES;
        end
        r.module_mask = '0;
        r.module_mask[bit_no] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic issue_request(input frame_req_t r);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_module_mask <= r.module_mask;
    in_put_buffer <= r.put_buffer;
    in_capture_ready <= r.capture_ready;
    in_capture_buffer <= r.capture_buffer;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tracker.note_request(r);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_request(compose_request(REQ_GET, 8'h01, 3'd0, 1'b1, 3'd3));
    issue_request(compose_request(REQ_GET, 8'h01, 3'd0, 1'b0, 3'd3));
    issue_request(compose_request(REQ_GET, 8'h02, 3'd0, 1'b1, 3'd5));
    issue_request(compose_request(REQ_GET, 8'h00, 3'd0, 1'b1, 3'd5));
    issue_request(compose_request(REQ_PUT, 8'h00, 3'd3, 1'b0, 3'd0));
    issue_request(compose_request(REQ_PUT, 8'h01, 3'd5, 1'b0, 3'd0));
    issue_request(compose_request(REQ_PUT, 8'h80, 3'd3, 1'b0, 3'd0));
    issue_request(compose_request(REQ_PUT, 8'h01, 3'd3, 1'b0, 3'd0));
    issue_request(compose_request(REQ_PUT, 8'h01, 3'd3, 1'b0, 3'd0));
    issue_request(compose_request(REQ_GET, 8'h01, 3'd7, 1'b1, 3'd3));
    issue_request(compose_request(REQ_PUT, 8'h02, 3'd3, 1'b0, 3'd0));
    for (int b = 0; b < BUFFERS; b++) begin
      issue_request(compose_request(REQ_GET, 8'hFF, 3'd0, 1'b1, BUF_W'(b)));
    end
    issue_request(compose_request(REQ_GET, 8'hFF, 3'd7, 1'b1, 3'd7));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 300) begin
        in_valid <= 1'b0;
        while (tracker.pending() != 0) begin
          @(posedge clk);
        end
      end
      issue_request(draw_request());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    for (int w = 0; w < 100000 && tracker.pending() != 0; w++) begin
      @(posedge clk);
    end
    repeat (SLOTS + 4) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.report_mismatch($sformatf("%0d replies never arrived", tracker.pending()));
    end
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : reply_monitor
    frame_reply_t seen;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        seen.status = out_status;
        seen.buffer_index = out_buffer_index;
        seen.frame_seq = out_frame_seq;
        seen.requeue = out_requeue;
        seen.consume_capture = out_consume_capture;
        seen.slot_used = out_slot_used;
        seen.ref_count = out_ref_count;
        tracker.check_reply(seen);
      end
      out_ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  initial begin : watchdog
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sfrt_pkg.sv
rtl/sfrt_cell.sv
rtl/shared_frame_refcount_table.sv
rtl/sfrt_checker.sv
test/shared_frame_refcount_table_tb.sv
